### src/ddo_pkg.sv
// shared types, constants and the arctangent table for the odometry core
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] MM_PER_TICK_RST    = 32'd65536;
    localparam logic [31:0] TURNS_PER_TICK_RST = 32'd65536;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [31:0]        TWO_PI_Q29      = 32'd3373259426;

    // distance divide: 512000 = 4096 * 125
    localparam int DIV_SHIFT = 12;
    localparam int DIV_CONST = 125;
    localparam int DIV_IN_W  = 36;
    localparam int QUO_W     = 30;

    // floor(2^38 / 125); n * DIV_RECIP >> 38 is floor(n / 125) or one short below 2^36
    localparam logic [31:0] DIV_RECIP       = 32'd2199023255;
    localparam int          DIV_RECIP_SHIFT = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MM_PER_TICK    = 1'b0,
        CFG_TURNS_PER_TICK = 1'b1
    } ddo_cfg_idx_t;

    typedef enum logic {
        OP_UPDATE   = 1'b0,
        OP_SET_POSE = 1'b1
    } ddo_op_t;

    typedef struct packed {
        logic accept;
        logic delta;
        logic mul;
        logic head;
        logic start;
        logic proj;
        logic accum;
        logic out_load;
    } ddo_cmd_t;

    typedef struct packed {
        logic set_pose;
        logic iter_done;
    } ddo_stat_t;

    // atan(2^-i) as a fraction of one turn, Q0.32
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

### src/ddo_cordic.sv
// iterative rotation-mode cordic giving cos and sin of a heading in turns
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out,
    output logic               done
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         quad_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [32:0] z_reg;

    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [32:0] at;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = $signed({1'b0, atan_turn(ATAN_IDX_W'(step_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= angle[31:30];
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[29:0]});
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    // fold the first-quadrant result back into the full turn
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1:
            begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2:
            begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default:
            begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign done = !busy_reg;

endmodule

### src/ddo_div.sv
// divide by the constant 125 through a reciprocal multiply, a sum and a remainder correction
module ddo_div
    import ddo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_IN_W-1:0] dividend,
    output logic [QUO_W-1:0]    quotient,
    output logic                done
);

    localparam int HALF_W = DIV_IN_W / 2;
    localparam int PP_W   = HALF_W + 32;
    localparam int ACC_W  = PP_W + HALF_W;
    localparam logic [1:0] CNT_MUL  = 2'd0;
    localparam logic [1:0] CNT_SUM  = 2'd1;
    localparam logic [1:0] LAST_CNT = 2'd2;
    localparam logic [DIV_IN_W-1:0] DIVISOR = DIV_IN_W'(DIV_CONST);

    logic                busy_reg;
    logic [1:0]          cnt_reg;
    logic [DIV_IN_W-1:0] n_reg;
    logic [PP_W-1:0]     lo_reg;
    logic [PP_W-1:0]     hi_reg;
    logic [QUO_W-1:0]    q_reg;

    logic [ACC_W-1:0]    acc;
    logic [DIV_IN_W-1:0] q_ext;
    logic [DIV_IN_W-1:0] rem;

    assign acc   = {hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_reg};
    assign q_ext = DIV_IN_W'(q_reg);
    // 125 q = 128 q - 4 q + q
    assign rem   = n_reg - ((q_ext << 7) - (q_ext << 2) + q_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
        end
        else if (busy_reg)
        begin
            case (cnt_reg)
                CNT_MUL:
                begin
                    lo_reg <= PP_W'(n_reg[HALF_W-1:0]) * PP_W'(DIV_RECIP);
                    hi_reg <= PP_W'(n_reg[DIV_IN_W-1:HALF_W]) * PP_W'(DIV_RECIP);
                end
                CNT_SUM:
                begin
                    // estimate is exact or one short
                    q_reg <= acc[DIV_RECIP_SHIFT + QUO_W - 1 : DIV_RECIP_SHIFT];
                end
                LAST_CNT:
                begin
                    if (rem >= DIVISOR)
                    begin
                        q_reg <= q_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // input stays below 2^36, so the quotient fits in 30 bits
    assign quotient = q_reg;
    assign done     = !busy_reg;

endmodule

### src/ddo_datapath.sv
// odometry datapath: wheel totals, pose state, multipliers and the two iterative units
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddo_cmd_t              cmd,
    output ddo_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  op,
    input  logic signed [15:0]    left_count,
    input  logic signed [15:0]    right_count,
    input  logic signed [31:0]    pose_x,
    input  logic signed [31:0]    pose_y,
    input  logic [15:0]           pose_heading,
    output logic signed [31:0]    x_pos,
    output logic signed [31:0]    y_pos,
    output logic [18:0]           heading_rad
);

    // beat payload
    logic        op_reg;
    logic [15:0] lc_reg;
    logic [15:0] rc_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [15:0] ph_reg;

    // configuration and architectural state
    logic [31:0] mm_reg;
    logic [31:0] turns_reg;
    logic [31:0] lt_reg;
    logic [31:0] rt_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [15:0] off_reg;

    // intermediate results
    logic signed [16:0] sum_reg;
    logic signed [49:0] prod_reg;
    logic [31:0]        raw_reg;
    logic [31:0]        h_reg;
    logic               neg_reg;
    logic signed [62:0] xp_reg;
    logic signed [62:0] yp_reg;
    logic [18:0]        hr_reg;

    // output buffer
    logic [31:0] x_out_reg;
    logic [31:0] y_out_reg;
    logic [18:0] hr_out_reg;

    logic               set_pose;
    logic [15:0]        dl;
    logic [15:0]        dr;
    logic signed [32:0] diff;
    logic signed [32:0] half;
    logic [31:0]        raw_next;
    logic signed [49:0] prod_next;
    logic [49:0]        prod_abs;
    logic [DIV_IN_W-1:0] dividend;
    logic [QUO_W-1:0]   quo;
    logic signed [30:0] dist_q16;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic [63:0]        hr_full;
    logic               cordic_done;
    logic               div_done;

    assign set_pose = (op_reg == OP_SET_POSE);

    assign dl = lc_reg - lt_reg[15:0];
    assign dr = rc_reg - rt_reg[15:0];

    // half difference, truncated toward zero
    assign diff     = $signed({rt_reg[31], rt_reg}) - $signed({lt_reg[31], lt_reg});
    assign half     = (diff + $signed({32'b0, diff[32]})) >>> 1;
    assign raw_next = half[31:0] * turns_reg;

    assign prod_next = 50'(sum_reg) * 50'($signed({1'b0, mm_reg}));
    assign prod_abs  = prod_reg[49] ? 50'(-prod_reg) : prod_reg;
    assign dividend  = prod_abs[DIV_SHIFT + DIV_IN_W - 1 : DIV_SHIFT];

    assign dist_q16 = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    assign hr_full = {32'b0, h_reg} * {32'b0, TWO_PI_Q29};

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .angle  (h_reg),
        .cos_out(cos_v),
        .sin_out(sin_v),
        .done   (cordic_done)
    );

    ddo_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start),
        .dividend(dividend),
        .quotient(quo),
        .done    (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_reg    <= MM_PER_TICK_RST;
            turns_reg <= TURNS_PER_TICK_RST;
            lt_reg    <= '0;
            rt_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            off_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (ddo_cfg_idx_t'(cfg_index))
                    CFG_MM_PER_TICK:    mm_reg    <= cfg_data;
                    CFG_TURNS_PER_TICK: turns_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.delta)
            begin
                if (set_pose)
                begin
                    lt_reg <= {{16{lc_reg[15]}}, lc_reg};
                    rt_reg <= {{16{rc_reg[15]}}, rc_reg};
                    x_reg  <= px_reg;
                    y_reg  <= py_reg;
                end
                else
                begin
                    lt_reg <= lt_reg + {{16{dl[15]}}, dl};
                    rt_reg <= rt_reg + {{16{dr[15]}}, dr};
                end
            end
            if (cmd.head && set_pose)
            begin
                off_reg <= ph_reg - raw_reg[31:16];
            end
            if (cmd.accum && !set_pose)
            begin
                x_reg <= x_reg + xp_reg[61:30];
                y_reg <= y_reg + yp_reg[61:30];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= op;
            lc_reg <= left_count;
            rc_reg <= right_count;
            px_reg <= pose_x;
            py_reg <= pose_y;
            ph_reg <= pose_heading;
        end
        if (cmd.delta)
        begin
            sum_reg <= $signed({dl[15], dl}) + $signed({dr[15], dr});
        end
        if (cmd.mul)
        begin
            raw_reg  <= raw_next;
            prod_reg <= prod_next;
        end
        if (cmd.head)
        begin
            // set pose keeps the fine bits of the heading and forces the coarse ones
            h_reg <= set_pose ? {ph_reg, raw_reg[15:0]} : raw_reg + {off_reg, 16'b0};
        end
        if (cmd.start)
        begin
            neg_reg <= prod_reg[49];
        end
        if (cmd.proj)
        begin
            xp_reg <= 63'(dist_q16) * 63'(cos_v);
            yp_reg <= 63'(dist_q16) * 63'(sin_v);
            hr_reg <= hr_full[63:45];
        end
        if (cmd.out_load)
        begin
            x_out_reg  <= x_reg;
            y_out_reg  <= y_reg;
            hr_out_reg <= hr_reg;
        end
    end

    assign stat.set_pose  = set_pose;
    assign stat.iter_done = cordic_done & div_done;

    assign x_pos       = $signed(x_out_reg);
    assign y_pos       = $signed(y_out_reg);
    assign heading_rad = hr_out_reg;

endmodule

### src/ddo_ctrl.sv
// sequencer for the odometry datapath and the output handshake
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ddo_stat_t stat,
    output ddo_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL,
        ST_HEAD,
        ST_START,
        ST_WAIT,
        ST_PROJ,
        ST_ACCUM,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.delta    = (state_reg == ST_DELTA);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.head     = (state_reg == ST_HEAD);
        cmd.start    = (state_reg == ST_START);
        cmd.proj     = (state_reg == ST_PROJ);
        cmd.accum    = (state_reg == ST_ACCUM);
        // the buffer frees up in the same cycle its beat is taken
        cmd.out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DELTA;
            ST_DELTA: state_next = ST_MUL;
            ST_MUL:   state_next = ST_HEAD;
            ST_HEAD:  state_next = stat.set_pose ? ST_PROJ : ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (stat.iter_done) state_next = ST_PROJ;
            ST_PROJ:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_DONE;
            ST_DONE:  if (cmd.out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/diff_drive_odometry_core.sv
// encoder sample: the result is buffered after the delta, multiply, heading, start, wait,
// projection and accumulate states; wait holds until cordic and divide by 125 are done
// set pose: skips the start and wait states, going from heading straight to projection
// one item in flight; the next input beat is taken the cycle after the result is buffered,
// and the buffered result may still be waiting on the output side
// rst_n clears pose, wheel totals and heading offset to zero and the registers to 65536
module diff_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic signed [15:0]    left_count,
    input  logic signed [15:0]    right_count,
    input  logic signed [31:0]    pose_x,
    input  logic signed [31:0]    pose_y,
    input  logic [15:0]           pose_heading,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    x_pos,
    output logic signed [31:0]    y_pos,
    output logic [18:0]           heading_rad
);

    ddo_cmd_t  cmd;
    ddo_stat_t stat;

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .left_count  (left_count),
        .right_count (right_count),
        .pose_x      (pose_x),
        .pose_y      (pose_y),
        .pose_heading(pose_heading),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .heading_rad (heading_rad)
    );

    // one item at a time: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("input beat taken while an item is in flight");

    // projection of a sample only uses finished cordic and divider results
    a_iter_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.proj && !stat.set_pose) |-> stat.iter_done)
        else $error("projection started before the iterative units finished");

    // a result only appears when the datapath loads the output buffer
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output beat raised without a buffer load");

endmodule

### tb/diff_drive_odometry_core_test.sv
// self-checking testbench for the differential drive odometry core
`timescale 1ns / 1ps

module diff_drive_odometry_core_test;
    import ddo_pkg::*;

    localparam int          STALL_MAX     = 13;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          CORDIC_N      = CORDIC_STEPS_DEF;
    localparam longint      UNIT_GAIN     = 652032874;
    localparam logic [31:0] RAD_PER_TURN  = 32'd3373259426;
    localparam longint      MM_TO_Q16     = 512000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [18:0]        hrad;
    } odo_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic signed [15:0]    left_count;
    logic signed [15:0]    right_count;
    logic signed [31:0]    pose_x;
    logic signed [31:0]    pose_y;
    logic [15:0]           pose_heading;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [31:0]    x_pos;
    logic signed [31:0]    y_pos;
    logic [18:0]           heading_rad;

    diff_drive_odometry_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .left_count   (left_count),
        .right_count  (right_count),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .heading_rad  (heading_rad)
    );

    // arctangent of 2^-i in turns, Q0.32
    logic [31:0] atan_tab [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // predictor copy of registers and pose state
    logic [31:0] mm_reg;
    logic [31:0] turn_reg;
    logic [31:0] left_sum;
    logic [31:0] right_sum;
    logic [31:0] x_sum;
    logic [31:0] y_sum;
    logic [15:0] head_off;

    odo_result_t pending_poses [$];
    odo_result_t want;
    int          errors;
    int          cycle_count;
    bit          tx_idle;
    bit          rx_idle;
    int          rx_hold_len;
    logic [15:0] sent_left;
    logic [15:0] sent_right;

    always #1 clk = ~clk;

    function automatic logic [31:0] half_diff_turns(input logic [31:0] lt, input logic [31:0] rt);
        longint half;
        longint prod;
        half = (longint'($signed(rt)) - longint'($signed(lt))) / 2;
        prod = half * longint'({32'd0, turn_reg});
        return prod[31:0];
    endfunction

    function automatic void rotate_unit(input logic [31:0] h, output longint c, output longint s);
        longint vx;
        longint vy;
        longint z;
        longint xs;
        longint ys;
        int     i;
        vx = UNIT_GAIN;
        vy = 0;
        z  = longint'(h[29:0]);
        for (i = 0; i < CORDIC_N && i < 24; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0)
            begin
                vx = vx - ys;
                vy = vy + xs;
                z  = z - longint'(atan_tab[i]);
            end
            else
            begin
                vx = vx + ys;
                vy = vy - xs;
                z  = z + longint'(atan_tab[i]);
            end
        end
        // fold the quadrant back in
        case (h[31:30])
            2'd0:    begin c = vx;  s = vy;  end
            2'd1:    begin c = -vy; s = vx;  end
            2'd2:    begin c = -vx; s = -vy; end
            default: begin c = vy;  s = -vx; end
        endcase
    endfunction

    function automatic odo_result_t advance_odometry(input ddo_op_t o,
                                                     input logic [15:0] lc,
                                                     input logic [15:0] rc,
                                                     input logic [31:0] px,
                                                     input logic [31:0] py,
                                                     input logic [15:0] ph);
        logic [31:0] h;
        logic [15:0] dl;
        logic [15:0] dr;
        logic [63:0] hr;
        longint      travel;
        longint      c;
        longint      s;
        longint      inc;
        odo_result_t r;
        if (o == OP_SET_POSE)
        begin
            left_sum  = {{16{lc[15]}}, lc};
            right_sum = {{16{rc[15]}}, rc};
            x_sum     = px;
            y_sum     = py;
            h         = half_diff_turns(left_sum, right_sum);
            head_off  = ph - h[31:16];
            h         = h + {head_off, 16'd0};
        end
        else
        begin
            // 16 bit difference read as signed: at most one counter wrap
            dl        = lc - left_sum[15:0];
            dr        = rc - right_sum[15:0];
            left_sum  = left_sum + {{16{dl[15]}}, dl};
            right_sum = right_sum + {{16{dr[15]}}, dr};
            travel = ((longint'($signed(dl)) + longint'($signed(dr))) * longint'({32'd0, mm_reg}))
                     / MM_TO_Q16;
            h = half_diff_turns(left_sum, right_sum) + {head_off, 16'd0};
            rotate_unit(h, c, s);
            inc   = (travel * c) >>> 30;
            x_sum = x_sum + inc[31:0];
            inc   = (travel * s) >>> 30;
            y_sum = y_sum + inc[31:0];
        end
        hr     = {32'd0, h} * {32'd0, RAD_PER_TURN};
        r.x    = x_sum;
        r.y    = y_sum;
        r.hrad = hr[63:45];
        return r;
    endfunction

    task automatic send_item(input ddo_op_t o, input logic [15:0] lc, input logic [15:0] rc,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] ph);
        int gap;
        gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        left_count   <= lc;
        right_count  <= rc;
        pose_x       <= px;
        pose_y       <= py;
        pose_heading <= ph;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_poses.push_back(advance_odometry(o, lc, rc, px, py, ph));
        sent_left  = lc;
        sent_right = rc;
    endtask

    task automatic send_update(input logic [15:0] lc, input logic [15:0] rc);
        send_item(OP_UPDATE, lc, rc, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic send_random_item();
        int          pick;
        logic [15:0] lc;
        logic [15:0] rc;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            send_item(OP_SET_POSE, 16'($urandom), 16'($urandom), $urandom, $urandom,
                      16'($urandom));
        end
        else
        begin
            if (pick < 76)
            begin
                // ordinary driving: small steps on each wheel
                lc = sent_left + 16'($urandom_range(0, 400)) - 16'd200;
                rc = sent_right + 16'($urandom_range(0, 400)) - 16'd200;
            end
            else if (pick < 90)
            begin
                lc = 16'($urandom);
                rc = 16'($urandom);
            end
            else
            begin
                // jumps near half the counter range, either side of the sign flip
                lc = sent_left + 16'h8000 + 16'($urandom_range(0, 4)) - 16'd2;
                rc = sent_right + 16'h8000 + 16'($urandom_range(0, 4)) - 16'd2;
            end
            send_update(lc, rc);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ddo_cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MM_PER_TICK:    mm_reg   = val;
            CFG_TURNS_PER_TICK: turn_reg = val;
            default:            ;
        endcase
    endtask

    task automatic load_registers(input logic [31:0] mm, input logic [31:0] turns);
        wait_idle();
        write_reg(CFG_MM_PER_TICK, mm);
        write_reg(CFG_TURNS_PER_TICK, turns);
    endtask

    task automatic test_directed();
        send_item(OP_SET_POSE, 16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h80000000, 16'h0000);
        send_update(16'h0000, 16'h0000);
        send_update(16'h7FFF, 16'h7FFF);
        // crossing the counter sign flip is one tick forward
        send_update(16'h8000, 16'h8000);
        // a jump of exactly half the range reads as going backward
        send_update(16'h0000, 16'h0000);
        send_update(16'h0100, 16'hFF00);
        send_update(16'hFF00, 16'h0100);
        send_item(OP_SET_POSE, 16'h8000, 16'h7FFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
        send_update(16'h8400, 16'h83FF);
        send_item(OP_SET_POSE, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 16'h4000);
        send_update(16'h1000, 16'h1000);
        send_item(OP_SET_POSE, 16'h1000, 16'h1000, 32'h00000000, 32'h00000000, 16'h8000);
        send_update(16'h2000, 16'h2000);
        send_item(OP_SET_POSE, 16'h2000, 16'h2000, 32'h00000000, 32'h00000000, 16'hC000);
        send_update(16'h3000, 16'h3000);
        send_update(16'h2000, 16'h2000);
        send_item(OP_SET_POSE, 16'hFFFF, 16'h0001, 32'hFFFFFFFF, 32'h00000001, 16'h2000);
        send_update(16'h7FFF, 16'h8001);
        send_update(16'h8001, 16'h7FFF);
        send_update(16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        logic [31:0] mm_vals [3];
        logic [31:0] turn_vals [3];
        int          i;
        int          j;
        int          k;
        mm_vals   = '{32'd1, 32'hFFFFFFFF, 32'd0};
        turn_vals = '{32'd1, 32'hFFFFFFFF, 32'd0};
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                load_registers(mm_vals[i], turn_vals[j]);
                for (k = 0; k < 4; k++)
                    send_random_item();
            end
        end
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: load_registers(MM_PER_TICK_RST, TURNS_PER_TICK_RST);
                1: load_registers($urandom, $urandom);
                2: load_registers(32'hFFFFFFFF, $urandom_range(1, 65536));
                3: load_registers($urandom_range(1, 255), 32'hFFFFFFFF);
                default: load_registers(32'h00800000, 32'd1073742);
            endcase
            tx_idle = (phase != 1) && (phase != 3);
            rx_idle = (phase != 1) && (phase != 2);
            for (n = 0; n < 190; n++)
                send_random_item();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        int n;
        wait_idle();
        tx_idle     = 1'b0;
        rx_hold_len = 400;
        for (n = 0; n < 16; n++)
            send_random_item();
        wait_idle();
        tx_idle = 1'b1;
    endtask

    // result side: random hold-off for each beat while rx_idle is set, or one long stall on request
    initial
    begin
        int w;
        forever
        begin
            if (rx_hold_len > 0)
            begin
                w           = rx_hold_len;
                rx_hold_len = 0;
            end
            else
            begin
                w = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
            end
            @(negedge clk);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat x_pos %h y_pos %h heading_rad %h",
                         $time, x_pos, y_pos, heading_rad);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (x_pos !== want.x)
                begin
                    errors++;
                    $display("%0t: x_pos expected %h actual %h", $time, want.x, x_pos);
                end
                if (y_pos !== want.y)
                begin
                    errors++;
                    $display("%0t: y_pos expected %h actual %h", $time, want.y, y_pos);
                end
                if (heading_rad !== want.hrad)
                begin
                    errors++;
                    $display("%0t: heading_rad expected %h actual %h",
                             $time, want.hrad, heading_rad);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MM_PER_TICK;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = OP_UPDATE;
        left_count   = '0;
        right_count  = '0;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        out_ready    = 1'b0;
        errors       = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold_len  = 0;
        sent_left    = '0;
        sent_right   = '0;
        mm_reg       = MM_PER_TICK_RST;
        turn_reg     = TURNS_PER_TICK_RST;
        left_sum     = '0;
        right_sum    = '0;
        x_sum        = '0;
        y_sum        = '0;
        head_off     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_register_extremes();
        test_random_phases();
        test_output_stall();

        wait_idle();
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
src/ddo_pkg.sv
src/ddo_cordic.sv
src/ddo_div.sv
src/ddo_datapath.sv
src/ddo_ctrl.sv
src/diff_drive_odometry_core.sv
tb/diff_drive_odometry_core_test.sv
